FILE: rtl/crqe_pkg.sv
// crqe_pkg: shared types, codes and a helper function of the cfg reachability query engine
// no dependencies; crqe_ctrl, crqe_dp, the top level and the checker refer to it by scoped names

package crqe_pkg;

   localparam int unsigned MASK_WIDTH      = 64;
   localparam int unsigned INDEX_WIDTH     = 6;
   localparam int unsigned COUNT_WIDTH     = 7;
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 7;

   // register indexes of the csr port
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BLOCK_COUNT      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DOMINATORS_VALID = 2'd1;

   typedef enum logic [1:0] {
      ACT_LOAD    = 2'd0,
      ACT_REACH   = 2'd1,
      ACT_DOM     = 2'd2,
      ACT_BARRIER = 2'd3
   } action_type;

   typedef struct packed {
      action_type                  action;
      logic [INDEX_WIDTH-1:0]      block_index;
      logic [MASK_WIDTH-1:0]       successor_mask;
      logic                        has_barrier;
      logic [INDEX_WIDTH-1:0]      dominator_parent;
      logic [INDEX_WIDTH-1:0]      source_block;
      logic [INDEX_WIDTH-1:0]      sink_block;
   } req_type;

   typedef struct packed {
      logic answer;
      logic index_out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_LOAD,
      ST_SEARCH_ALL,
      ST_SEARCH_FREE,
      ST_DOM_TEST,
      ST_DOM_WAIT,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic load_write;
      logic search_start;
      logic search_expand_all;
      logic search_run;
      logic dom_init;
      logic dom_advance;
      logic res_write;
      logic res_answer;
      logic res_oor;
      logic rsp_push;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type action;
      logic       index_oor;
      logic       same_block;
      logic       dominators_valid;
      logic       source_is_zero;
      logic       search_done;
      logic       sink_visited;
      logic       sink_barrier;
      logic       step_over;
      logic       cur_is_source;
      logic       parent_bad;
      logic       rsp_busy;
   } dp_status_type;

   // index of the single set bit of a one-hot word (or-tree encoder)
   function automatic logic [INDEX_WIDTH-1:0] onehot_to_index(
      input logic [MASK_WIDTH-1:0] one_hot
   );
      logic [INDEX_WIDTH-1:0] idx;
      logic [INDEX_WIDTH-1:0] pos;
      idx = '0;
      for (int i = 0; i < MASK_WIDTH; i++) begin
         pos = INDEX_WIDTH'(i);
         for (int k = 0; k < INDEX_WIDTH; k++) begin
            idx[k] = idx[k] | (one_hot[i] & pos[k]);
         end
      end
      return idx;
   endfunction

endpackage

FILE: rtl/crqe_ram.sv
// crqe_ram: generic single-write, single-read memory with registered read data
// no dependencies

module crqe_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/crqe_ctrl.sv
// crqe_ctrl: sequencing state machine of the query engine
// depends on crqe_pkg; drives the command struct of crqe_dp and reads its status struct

module crqe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  crqe_pkg::dp_status_type status,
   output crqe_pkg::ctrl_cmd_type  cmd
);

   crqe_pkg::state_type state_ff;
   crqe_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= crqe_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         crqe_pkg::ST_IDLE: begin
            if (req_valid) state_in = crqe_pkg::ST_DECODE;
         end
         crqe_pkg::ST_DECODE: begin
            if (status.action == crqe_pkg::ACT_LOAD) begin
               state_in = crqe_pkg::ST_LOAD;
            end else if (status.index_oor) begin
               state_in = crqe_pkg::ST_FINISH;
            end else begin
               case (status.action)
                  crqe_pkg::ACT_REACH, crqe_pkg::ACT_BARRIER: begin
                     state_in = status.same_block ? crqe_pkg::ST_FINISH
                                                  : crqe_pkg::ST_SEARCH_ALL;
                  end
                  crqe_pkg::ACT_DOM: begin
                     state_in = status.dominators_valid ? crqe_pkg::ST_DOM_TEST
                                                        : crqe_pkg::ST_FINISH;
                  end
                  default: state_in = crqe_pkg::ST_FINISH;
               endcase
            end
         end
         crqe_pkg::ST_LOAD: begin
            state_in = crqe_pkg::ST_FINISH;
         end
         crqe_pkg::ST_SEARCH_ALL: begin
            if (status.search_done) begin
               if (status.action == crqe_pkg::ACT_BARRIER && status.sink_visited &&
                   !status.sink_barrier) begin
                  state_in = crqe_pkg::ST_SEARCH_FREE;
               end else begin
                  state_in = crqe_pkg::ST_FINISH;
               end
            end
         end
         crqe_pkg::ST_SEARCH_FREE: begin
            if (status.search_done) state_in = crqe_pkg::ST_FINISH;
         end
         crqe_pkg::ST_DOM_TEST: begin
            if (status.step_over || status.cur_is_source) begin
               state_in = crqe_pkg::ST_FINISH;
            end else begin
               state_in = crqe_pkg::ST_DOM_WAIT;
            end
         end
         crqe_pkg::ST_DOM_WAIT: begin
            state_in = status.parent_bad ? crqe_pkg::ST_FINISH : crqe_pkg::ST_DOM_TEST;
         end
         crqe_pkg::ST_FINISH: begin
            if (!status.rsp_busy) state_in = crqe_pkg::ST_IDLE;
         end
         default: state_in = crqe_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         crqe_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         crqe_pkg::ST_DECODE: begin
            if (status.action == crqe_pkg::ACT_LOAD) begin
               cmd.res_write = 1'b0;
            end else if (status.index_oor) begin
               cmd.res_write = 1'b1;
               cmd.res_oor   = 1'b1;
            end else begin
               case (status.action)
                  crqe_pkg::ACT_REACH: begin
                     if (status.same_block) begin
                        cmd.res_write  = 1'b1;
                        cmd.res_answer = 1'b1;
                     end else begin
                        cmd.search_start      = 1'b1;
                        cmd.search_expand_all = 1'b1;
                     end
                  end
                  crqe_pkg::ACT_DOM: begin
                     if (status.dominators_valid) begin
                        cmd.dom_init = 1'b1;
                     end else begin
                        cmd.res_write  = 1'b1;
                        cmd.res_answer = status.source_is_zero;
                     end
                  end
                  crqe_pkg::ACT_BARRIER: begin
                     if (status.same_block) begin
                        cmd.res_write = 1'b1;
                     end else begin
                        cmd.search_start      = 1'b1;
                        cmd.search_expand_all = 1'b1;
                     end
                  end
                  default: cmd.res_write = 1'b1;
               endcase
            end
         end
         crqe_pkg::ST_LOAD: begin
            cmd.load_write = 1'b1;
            cmd.res_write  = 1'b1;
         end
         crqe_pkg::ST_SEARCH_ALL: begin
            cmd.search_run = 1'b1;
            if (status.search_done) begin
               if (status.action == crqe_pkg::ACT_REACH) begin
                  cmd.res_write  = 1'b1;
                  cmd.res_answer = status.sink_visited;
               end else if (!status.sink_visited) begin
                  cmd.res_write = 1'b1;
               end else if (status.sink_barrier) begin
                  cmd.res_write  = 1'b1;
                  cmd.res_answer = 1'b1;
               end else begin
                  cmd.search_start = 1'b1;
               end
            end
         end
         crqe_pkg::ST_SEARCH_FREE: begin
            cmd.search_run = 1'b1;
            if (status.search_done) begin
               cmd.res_write  = 1'b1;
               cmd.res_answer = !status.sink_visited;
            end
         end
         crqe_pkg::ST_DOM_TEST: begin
            if (status.step_over) begin
               cmd.res_write = 1'b1;
            end else if (status.cur_is_source) begin
               cmd.res_write  = 1'b1;
               cmd.res_answer = 1'b1;
            end
         end
         crqe_pkg::ST_DOM_WAIT: begin
            if (status.parent_bad) begin
               cmd.res_write = 1'b1;
            end else begin
               cmd.dom_advance = 1'b1;
            end
         end
         crqe_pkg::ST_FINISH: begin
            cmd.rsp_push = !status.rsp_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule

FILE: rtl/crqe_dp.sv
// crqe_dp: datapath of the query engine: item register, csr registers, graph stores,
// search sets, dominator walk and result register; depends on crqe_pkg and crqe_ram

module crqe_dp #(
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  crqe_pkg::req_type                       req_data,
   input  logic                                    csr_we,
   input  logic [crqe_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [crqe_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata,
   input  crqe_pkg::ctrl_cmd_type                  cmd,
   output crqe_pkg::dp_status_type                 status,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output crqe_pkg::rsp_type                       rsp_data
);

   localparam int unsigned AW = $clog2(MAX_BLOCKS);
   localparam int unsigned MW = crqe_pkg::MASK_WIDTH;
   localparam int unsigned IW = crqe_pkg::INDEX_WIDTH;
   localparam int unsigned CW = crqe_pkg::COUNT_WIDTH;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_BLOCKS);

   crqe_pkg::req_type     item_ff;
   logic [CW-1:0]         block_count_ff;
   logic                  dom_valid_ff;
   logic [MAX_BLOCKS-1:0] barrier_ff;
   logic [MW-1:0]         visited_ff, visited_in;
   logic [MW-1:0]         pending_ff, pending_in;
   logic [MW-1:0]         expand_ff, expand_in;
   logic                  inflight_ff, inflight_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [CW-1:0]         step_ff, step_in;
   logic                  res_answer_ff, res_oor_ff;
   logic                  rsp_valid_ff;
   crqe_pkg::rsp_type     rsp_data_ff;

   logic [CW-1:0] live_count;
   logic [MW-1:0] live_mask;
   logic [MW-1:0] barrier_wide;
   logic [MW-1:0] low_bit;
   logic [IW-1:0] issue_index;
   logic [MW-1:0] succ_rd_data;
   logic [MW-1:0] fresh;
   logic [IW-1:0] parent_rd_data;
   logic          load_ok;
   logic [AW-1:0] load_addr;

   // effective block count saturates at the store depth
   assign live_count = (block_count_ff > MAX_COUNT) ? MAX_COUNT : block_count_ff;

   always_comb begin
      for (int i = 0; i < MW; i++) begin
         live_mask[i] = CW'(i) < live_count;
      end
   end

   assign barrier_wide = MW'(barrier_ff);
   assign load_ok      = {1'b0, item_ff.block_index} < MAX_COUNT;
   assign load_addr    = item_ff.block_index[AW-1:0];

   // lowest pending block goes to the successor store next
   assign low_bit     = pending_ff & (~pending_ff + MW'(1));
   assign issue_index = crqe_pkg::onehot_to_index(low_bit);
   assign fresh       = inflight_ff ? (succ_rd_data & live_mask & ~visited_ff) : '0;

   crqe_ram #(.WIDTH(MW), .DEPTH(MAX_BLOCKS)) u_succ_ram (
      .clock (clock),
      .we    (cmd.load_write && load_ok),
      .waddr (load_addr),
      .wdata (item_ff.successor_mask),
      .raddr (issue_index[AW-1:0]),
      .rdata (succ_rd_data)
   );

   crqe_ram #(.WIDTH(IW), .DEPTH(MAX_BLOCKS)) u_parent_ram (
      .clock (clock),
      .we    (cmd.load_write && load_ok),
      .waddr (load_addr),
      .wdata (item_ff.dominator_parent),
      .raddr (cur_ff[AW-1:0]),
      .rdata (parent_rd_data)
   );

   always_comb begin
      visited_in  = visited_ff;
      pending_in  = pending_ff;
      expand_in   = expand_ff;
      inflight_in = inflight_ff;
      if (cmd.search_start) begin
         visited_in  = MW'(1) << item_ff.source_block;
         pending_in  = MW'(1) << item_ff.source_block;
         expand_in   = cmd.search_expand_all ? '1 : ~barrier_wide;
         inflight_in = 1'b0;
      end else if (cmd.search_run) begin
         visited_in  = visited_ff | fresh;
         pending_in  = (pending_ff & ~low_bit) | (fresh & expand_ff);
         inflight_in = pending_ff != '0;
      end
   end

   always_comb begin
      cur_in  = cur_ff;
      step_in = step_ff;
      if (cmd.dom_init) begin
         cur_in  = item_ff.sink_block;
         step_in = '0;
      end else if (cmd.dom_advance) begin
         cur_in  = parent_rd_data;
         step_in = step_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= CW'(1);
         dom_valid_ff   <= 1'b0;
         barrier_ff     <= '0;
         visited_ff     <= '0;
         pending_ff     <= '0;
         inflight_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               crqe_pkg::CSR_BLOCK_COUNT:      block_count_ff <= csr_wdata;
               crqe_pkg::CSR_DOMINATORS_VALID: dom_valid_ff   <= csr_wdata[0];
               default: ;
            endcase
         end
         if (cmd.load_write && load_ok) begin
            barrier_ff[load_addr] <= item_ff.has_barrier;
         end
         visited_ff  <= visited_in;
         pending_ff  <= pending_in;
         inflight_ff <= inflight_in;
         if (cmd.rsp_push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) item_ff <= req_data;
      expand_ff <= expand_in;
      cur_ff    <= cur_in;
      step_ff   <= step_in;
      if (cmd.res_write) begin
         res_answer_ff <= cmd.res_answer;
         res_oor_ff    <= cmd.res_oor;
      end
      if (cmd.rsp_push) begin
         rsp_data_ff.answer             <= res_answer_ff;
         rsp_data_ff.index_out_of_range <= res_oor_ff;
      end
   end

   always_comb begin
      status.action           = item_ff.action;
      status.index_oor        = ({1'b0, item_ff.source_block} >= live_count) ||
                                ({1'b0, item_ff.sink_block} >= live_count);
      status.same_block       = item_ff.source_block == item_ff.sink_block;
      status.dominators_valid = dom_valid_ff;
      status.source_is_zero   = item_ff.source_block == '0;
      status.search_done      = (pending_ff == '0) && !inflight_ff;
      status.sink_visited     = visited_ff[item_ff.sink_block];
      status.sink_barrier     = barrier_wide[item_ff.sink_block];
      status.step_over        = step_ff > live_count;
      status.cur_is_source    = cur_ff == item_ff.source_block;
      status.parent_bad       = ({1'b0, parent_rd_data} >= live_count) ||
                                (parent_rd_data == cur_ff);
      status.rsp_busy         = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: rtl/cfg_reachability_query_engine.sv
// cfg_reachability_query_engine: top level of the control-flow graph query engine
// depends on crqe_pkg, crqe_ctrl, crqe_dp (which holds two crqe_ram stores)

// Holds a control-flow graph of up to MAX_BLOCKS blocks (successor row, barrier mark and
// immediate-dominator parent per block) and answers one query or load per req transfer
// with exactly one rsp transfer. Items are worked one at a time; a new item is taken
// while the previous result still waits in the output register. A load writes its
// entry in the load state; an out-of-range or trivial query goes from decode straight
// to the result; a reachable query runs one search that expands each reached block at
// most once; a barrier query runs up to two such searches; a dominates walk alternates
// a parent test and a parent read per step. A finished result also waits while the
// output register still holds an untaken result. The search rate is set by the
// successor store's single read port with registered read data: with several blocks
// pending one row read issues every cycle, but a block found only by the row just read
// is issued in the cycle after that row arrives; the walk rate is set by the parent
// store's read-then-check loop. Successor and parent entries have no reset: they must
// be loaded before a query reads them. Barrier marks reset to zero. Configuration
// (csr_index 0: block_count, 1: dominators_valid) must be written by the user only
// while the block is idle; the block itself does not enforce it.

module cfg_reachability_query_engine #(
   parameter int unsigned MAX_BLOCKS = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  crqe_pkg::req_type                    req_data,
   // result channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output crqe_pkg::rsp_type                    rsp_data,
   // configuration writes
   input  logic                                 csr_we,
   input  logic [crqe_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [crqe_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // command and status between sequencer and datapath
   crqe_pkg::ctrl_cmd_type  cmd;
   crqe_pkg::dp_status_type status;

   // sequencer: decode, search, walk, result handoff
   crqe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: item capture, graph stores, search sets, output register
   crqe_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/crqe_checker.sv
// crqe_checker: port-level assertions of the query engine, bound to the top level
// depends on crqe_pkg and cfg_reachability_query_engine

module crqe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input crqe_pkg::rsp_type rsp_data
);

   // items accepted whose result transfer has not happened yet
   logic [1:0] outstanding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_ff + 2'(req_valid && req_ready)
                                          - 2'(rsp_valid && rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.answer && rsp_data.index_out_of_range))
      else $error("out-of-range result carries a true answer");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("result without an accepted item");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff == 2'd2 |-> !req_ready && outstanding_ff != 2'd3)
      else $error("more than one item taken beyond the waiting result");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind cfg_reachability_query_engine crqe_checker u_crqe_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
